[hw/rtl/sbt_pkg.sv]
`default_nettype none
package sbt_pkg;

  localparam int NUM_BINS     = 1024;
  localparam int NUM_TRIGGERS = 4;
  localparam int MAG_WIDTH    = 16;
  localparam int BIN_BITS     = 10;
  localparam int TRIG_IDX_W   = 2;
  localparam int CNT_W        = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 36;
  localparam int SUM_W        = MAG_WIDTH + 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LAST  = 3'd4;

  // One trigger register: threshold in 35:20, high bin in 19:10, low bin in 9:0
  typedef struct packed {
    logic [MAG_WIDTH-1:0] thr;
    logic [BIN_BITS-1:0]  hi;
    logic [BIN_BITS-1:0]  lo;
  } trig_t;

  // One firing on its way to the output
  typedef struct packed {
    logic [TRIG_IDX_W-1:0] trig;
    logic [BIN_BITS-1:0]   bin;
    logic [MAG_WIDTH-1:0]  mag;
  } fire_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/sbt_cfg.sv]
`default_nettype none
module sbt_cfg
  import sbt_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  output trig_t     [NUM_TRIGGERS-1:0]      triggers,
  output logic      [CNT_W-1:0]             enabled
);

  logic [CNT_W-1:0] trigger_count;
  logic [TRIG_IDX_W-1:0] slot;

  assign slot = TRIG_IDX_W'(cfg_index - REG_TRIG_FIRST);

  // Take register writes; indexes past the last trigger are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_count <= '0;
      triggers      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TRIG_COUNT) begin
        trigger_count <= cfg_data[CNT_W-1:0];
      end else if (cfg_index >= REG_TRIG_FIRST && cfg_index <= REG_TRIG_LAST) begin
        triggers[slot] <= trig_t'(cfg_data);
      end
    end
  end

  // Clamp the enabled count to the number of triggers built
  assign enabled = (trigger_count > CNT_W'(NUM_TRIGGERS)) ? CNT_W'(NUM_TRIGGERS)
                                                          : trigger_count;

endmodule
`default_nettype wire

[hw/rtl/sbt_check.sv]
`default_nettype none
module sbt_check
  import sbt_pkg::*;
(
  input  trig_t                    trig,
  input  wire logic [BIN_BITS-1:0] bin,
  input  wire logic [SUM_W-1:0]    sum,
  output logic                     hit
);

  logic covers;
  logic loud;

  // Band test: either edge by equality, or strictly inside
  assign covers = (bin == trig.lo) || (bin == trig.hi) ||
                  ((trig.lo < bin) && (bin < trig.hi));

  // Compare the unrounded average: left + right >= 2 * threshold
  assign loud = sum >= {trig.thr, 1'b0};

  assign hit = covers && loud;

endmodule
`default_nettype wire

[hw/rtl/spectrum_band_trigger.sv]
// Sequence: accept a bin, then check each enabled trigger in turn, then close the scan;
// enabled is trigger_count clamped to four, and every trigger goes through the one
// shared checker. A new bin is accepted only after the previous scan closes, and a full
// output register stalls the scan.
// Reset (rst, synchronous, active high) clears bin counter, fired flags, configuration
// and all valid state; the block is ready in the cycle after reset.
`default_nettype none
module spectrum_band_trigger
  import sbt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [MAG_WIDTH-1:0]   left_mag,
  input  wire logic [MAG_WIDTH-1:0]   right_mag,
  input  wire logic                   frame_start,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [TRIG_IDX_W-1:0]       trigger_index,
  output logic [BIN_BITS-1:0]         bin_index,
  output logic [MAG_WIDTH-1:0]        magnitude,
  output logic                        last
);

  trig_t [NUM_TRIGGERS-1:0] triggers;
  logic  [CNT_W-1:0]        enabled;

  state_t                   state;
  logic [CNT_W-1:0]         k;
  logic [BIN_BITS-1:0]      bin_counter;
  logic [BIN_BITS-1:0]      bin;
  logic [SUM_W-1:0]         sum;
  logic [NUM_TRIGGERS-1:0]  fired_flags;
  logic                     pend_valid;
  fire_t                    pend;
  fire_t                    out_word;

  logic                     hit;
  logic                     found;
  logic                     out_free;
  logic                     out_load;
  logic                     scan_done;
  logic [TRIG_IDX_W-1:0]    slot;
  logic [BIN_BITS-1:0]      bin_next;

  sbt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .triggers  (triggers),
    .enabled   (enabled)
  );

  assign slot = k[TRIG_IDX_W-1:0];

  sbt_check u_check (
    .trig (triggers[slot]),
    .bin  (bin),
    .sum  (sum),
    .hit  (hit)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign scan_done = (k == enabled);
  assign found     = !scan_done && hit && !fired_flags[slot];
  assign bin_next  = frame_start ? '0 : bin_counter;
  assign out_load  = (state == ST_SCAN) && pend_valid && out_free && (scan_done || found);

  assign trigger_index = out_word.trig;
  assign bin_index     = out_word.bin;
  assign magnitude     = out_word.mag;

  // Sequencer: one trigger through the checker per cycle, unless a full output register stalls the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      k           <= '0;
      bin_counter <= '0;
      fired_flags <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Fill the output register, or release it once the word is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            bin         <= bin_next;
            bin_counter <= bin_next + BIN_BITS'(1);
            sum         <= SUM_W'(left_mag) + SUM_W'(right_mag);
            k           <= '0;
            state       <= ST_SCAN;
            if (frame_start) begin
              fired_flags <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            // Close: hand over the held firing marked as the last of this bin
            if (!pend_valid) begin
              state <= ST_IDLE;
            end else if (out_free) begin
              out_word   <= pend;
              last       <= 1'b1;
              pend_valid <= 1'b0;
              state      <= ST_IDLE;
            end
          end else if (found) begin
            // Hold the new firing; push the older one out, stalling if needed
            if (!pend_valid || out_free) begin
              if (pend_valid) begin
                out_word  <= pend;
                last      <= 1'b0;
              end
              pend.trig         <= slot;
              pend.bin          <= bin;
              pend.mag          <= sum[SUM_W-1:1];
              pend_valid        <= 1'b1;
              fired_flags[slot] <= 1'b1;
              k                 <= k + CNT_W'(1);
            end
          end else begin
            k <= k + CNT_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
